>>> hw/rtl/ucfc_pkg.sv
// shared types, constants and helpers for the uart command frame controller
// no dependencies; imported by every module of the block
`default_nettype none

package ucfc_pkg;

  // frame geometry
  localparam int FRAME_LEN = 10;
  localparam int DEC_LEN   = 8;
  localparam int FCNT_W    = $clog2(FRAME_LEN);
  localparam int DEC_IDX_W = $clog2(DEC_LEN);

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // status reply layout
  localparam int REPLY_LEN      = 42;
  localparam int RIDX_W         = $clog2(REPLY_LEN);
  localparam int REPLY_LED_POS  = 24;
  localparam int REPLY_LED_STEP = 5;
  localparam int REPLY_TEMP_POS = 35;
  localparam int TEMP_CHARS     = 4;

  // item kinds
  typedef enum logic [1:0] {
    FUNC_RX     = 2'd0,
    FUNC_TEMP   = 2'd1,
    FUNC_BUTTON = 2'd2
  } func_e;

  // ascii codes used by the command decoder and the reply
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  // temperature conversion constants
  localparam logic [15:0] TEMP_ERR    = 16'hFFFF;
  localparam logic [15:0] TEMP_NEG    = 16'h8000;
  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  // fixed reply bytes; led and temperature slots are filled in by the back end
  localparam logic [7:0] REPLY_ROM [REPLY_LEN] = '{
    8'h41, 8'h54, 8'h2B, 8'h43, 8'h49, 8'h50, 8'h53, 8'h45, 8'h4E, 8'h44,
    8'h3D, 8'h30, 8'h2C, 8'h32, 8'h36, 8'h0D, 8'h0A,
    8'h45, 8'h53, 8'h50,
    8'h4C, 8'h45, 8'h44, 8'h31, 8'h00,
    8'h4C, 8'h45, 8'h44, 8'h32, 8'h00,
    8'h4C, 8'h45, 8'h44, 8'h33, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h50, 8'h53, 8'h45
  };

  // input item
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [15:0] temp_raw;
    logic [1:0]  button_index;
  } in_t;

  // result item
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [2:0] led_levels;
    logic       relay_level;
    logic       beep_request;
  } out_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic [2:0]  led_clr;
    logic [2:0]  led_set;
    logic [2:0]  led_tgl;
    logic        relay_we;
    logic        relay_val;
    logic        beep;
    logic        reply;
    logic        temp_we;
    logic [15:0] temp_raw;
  } op_t;

  // exact x / 10 for any 16-bit x by reciprocal multiply
  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = {16'd0, x} * {16'd0, DIV10_MUL};
    return 16'(prod >> DIV10_SHIFT);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ucfc_front.sv
// front end: accepts items, assembles the command frame and classifies each item
// depends on ucfc_pkg; pushes one op per accepted item into ucfc_queue
`default_nettype none

module ucfc_front import ucfc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  input  wire logic q_full_i,
  output logic      push_o,
  output op_t       push_op_o
);

  logic [FCNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]        frame_q [DEC_LEN];
  logic [7:0]        fv [DEC_LEN];
  logic              accept, is_rx, anchor, full_frame;
  logic              esp, sel_on, sel_off, led_cmd, relay_cmd;
  logic [1:0]        led_sel;
  logic [2:0]        led_mask;
  op_t               op;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_rx      = in_data_i.func == FUNC_RX;

  // frame as it stands with the incoming byte merged in
  always_comb begin
    for (int i = 0; i < DEC_LEN; i++) begin
      fv[i] = (cnt_q == FCNT_W'(i)) ? in_data_i.rx_byte : frame_q[i];
    end
  end

  assign anchor     = fv[0] == CH_E;
  assign full_frame = anchor && (cnt_q == FCNT_W'(FRAME_LEN - 1));

  // byte count: restarts without the anchor or once the frame is full
  always_comb begin
    cnt_d = cnt_q;
    if (accept && is_rx) begin
      cnt_d = (anchor && !full_frame) ? cnt_q + FCNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // only the leading bytes take part in decoding
  always_ff @(posedge clk_i) begin
    if (accept && is_rx && ({1'b0, cnt_q} < (FCNT_W + 1)'(DEC_LEN))) begin
      frame_q[cnt_q[DEC_IDX_W-1:0]] <= in_data_i.rx_byte;
    end
  end

  // command field decode
  assign esp       = fv[0] == CH_E && fv[1] == CH_S && fv[2] == CH_P;
  assign sel_on    = fv[3] == CH_K;
  assign sel_off   = fv[3] == CH_G;
  assign led_cmd   = fv[4] == CH_L && fv[5] == CH_E && fv[6] == CH_D &&
                     fv[7] >= CH_ONE && fv[7] <= CH_THREE;
  assign relay_cmd = fv[4] == CH_J && fv[5] == CH_D && fv[6] == CH_Q &&
                     fv[7] == CH_ONE;
  assign led_sel   = 2'(fv[7] - CH_ONE);
  assign led_mask  = 3'b001 << led_sel;

  // classify the item
  always_comb begin
    op = '0;
    unique case (in_data_i.func)
      FUNC_RX: begin
        if (full_frame && esp) begin
          if (led_cmd && sel_on) begin
            op.led_clr = led_mask;
          end
          if (led_cmd && sel_off) begin
            op.led_set = led_mask;
          end
          if (relay_cmd && (sel_on || sel_off)) begin
            op.relay_we  = 1'b1;
            op.relay_val = sel_on;
          end
          op.beep  = fv[3] == CH_F && fv[4] == CH_M && fv[5] == CH_Q &&
                     fv[6] == CH_C && fv[7] == CH_S;
          op.reply = fv[3] == CH_C && fv[4] == CH_X && fv[5] == CH_S &&
                     fv[6] == CH_J;
        end
      end
      FUNC_TEMP: begin
        op.temp_we  = 1'b1;
        op.temp_raw = in_data_i.temp_raw;
      end
      FUNC_BUTTON: begin
        // index three shifts the bit out, so no led changes
        op.led_tgl = 3'b001 << in_data_i.button_index;
      end
      default: begin
        op = '0;
      end
    endcase
  end

  assign push_o    = accept;
  assign push_op_o = op;

endmodule

`default_nettype wire

>>> hw/rtl/ucfc_queue.sv
// short fifo of classified ops between the front and back ends
// depends on ucfc_pkg for the op type and depth
`default_nettype none

module ucfc_queue import ucfc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire op_t  push_op_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output op_t       op_o
);

  op_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign op_o    = mem_q[rptr_q];

  // pointer and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ucfc_tconv.sv
// temperature pipeline: raw reading to tenths, then to three ascii digits
// depends on ucfc_pkg; holds the stored temperature characters
`default_nettype none

module ucfc_tconv import ucfc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] raw_i,
  output logic [7:0]       temp_o [TEMP_CHARS]
);

  logic        vld1_q, vld2_q, vld3_q, vld4_q;
  logic [15:0] v1_q, v2_q;
  logic [12:0] q1_q, q1b_q;
  logic [9:0]  q2_q, q2b_q;
  logic [6:0]  q3_q;
  logic [3:0]  d0_q, d0b_q, d1_q, d2;
  logic [15:0] tenths, mag, mag5, raw5;
  logic [7:0]  chars_q [TEMP_CHARS];

  // raw reading to tenths of a degree, sign kept in the top bit
  always_comb begin
    mag  = 16'(~raw_i + 16'd1);
    mag5 = 16'({mag, 2'b00}) + mag;
    raw5 = 16'({raw_i, 2'b00}) + raw_i;
    if (raw_i == TEMP_ERR) begin
      tenths = TEMP_ERR;
    end else if (raw_i > TEMP_NEG) begin
      tenths = TEMP_NEG + (mag5 >> 3);
    end else begin
      tenths = raw5 >> 3;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
    end
  end

  // digit extraction, one divide by ten per stage
  always_ff @(posedge clk_i) begin
    v1_q  <= tenths;
    v2_q  <= v1_q;
    q1_q  <= 13'(div10(v1_q));
    d0_q  <= 4'(v2_q - 16'(q1_q) * 16'd10);
    q1b_q <= q1_q;
    q2_q  <= 10'(div10(16'(q1_q)));
    d0b_q <= d0_q;
    d1_q  <= 4'(q1b_q - 13'(q2_q) * 13'd10);
    q2b_q <= q2_q;
    q3_q  <= 7'(div10(16'(q2_q)));
  end

  assign d2 = 4'(q2b_q - 10'(q3_q) * 10'd10);

  // stored characters "dd.d"
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TEMP_CHARS; i++) begin
        chars_q[i] <= '0;
      end
    end else if (vld4_q) begin
      chars_q[0] <= CH_ZERO + {4'd0, d2};
      chars_q[1] <= CH_ZERO + {4'd0, d1_q};
      chars_q[2] <= CH_DOT;
      chars_q[3] <= CH_ZERO + {4'd0, d0b_q};
    end
  end

  assign temp_o = chars_q;

endmodule

`default_nettype wire

>>> hw/rtl/ucfc_back.sv
// back end: applies ops to led/relay state, sequences the status reply
// depends on ucfc_pkg and ucfc_tconv; drives the registered output channel
`default_nettype none

module ucfc_back import ucfc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  wire op_t  q_op_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;
  logic [2:0]        led_q, led_d, led_n;
  logic              relay_q, relay_d, relay_n;
  logic              busy_q, busy_d;
  logic [RIDX_W-1:0] idx_q, idx_d;
  logic              slot_free, pop, last_byte;
  logic [7:0]        rbyte;
  logic [7:0]        temp_chars [TEMP_CHARS];

  // temperature converter; chars land long before a reply reaches their slot
  ucfc_tconv u_tconv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pop && q_op_i.temp_we),
    .raw_i   (q_op_i.temp_raw),
    .temp_o  (temp_chars)
  );

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = !busy_q && q_valid_i && slot_free;
  assign last_byte = idx_q == RIDX_W'(REPLY_LEN - 1);
  assign led_n     = ((led_q & ~q_op_i.led_clr) | q_op_i.led_set) ^ q_op_i.led_tgl;
  assign relay_n   = q_op_i.relay_we ? q_op_i.relay_val : relay_q;

  // reply byte at the current index
  always_comb begin
    rbyte = REPLY_ROM[idx_q];
    case (idx_q)
      RIDX_W'(REPLY_LED_POS):                      rbyte = led_q[0] ? CH_G : CH_K;
      RIDX_W'(REPLY_LED_POS + REPLY_LED_STEP):     rbyte = led_q[1] ? CH_G : CH_K;
      RIDX_W'(REPLY_LED_POS + 2 * REPLY_LED_STEP): rbyte = led_q[2] ? CH_G : CH_K;
      RIDX_W'(REPLY_TEMP_POS):                     rbyte = temp_chars[0];
      RIDX_W'(REPLY_TEMP_POS + 1):                 rbyte = temp_chars[1];
      RIDX_W'(REPLY_TEMP_POS + 2):                 rbyte = temp_chars[2];
      RIDX_W'(REPLY_TEMP_POS + 3):                 rbyte = temp_chars[3];
      default:                                     rbyte = REPLY_ROM[idx_q];
    endcase
  end

  // op execution and output register load
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    led_d       = led_q;
    relay_d     = relay_q;
    busy_d      = busy_q;
    idx_d       = idx_q;
    if (busy_q && slot_free) begin
      out_valid_d        = 1'b1;
      out_d.tx_valid     = 1'b1;
      out_d.tx_byte      = rbyte;
      out_d.last         = last_byte;
      out_d.led_levels   = led_q;
      out_d.relay_level  = relay_q;
      out_d.beep_request = 1'b0;
      idx_d              = idx_q + RIDX_W'(1);
      if (last_byte) begin
        busy_d = 1'b0;
      end
    end else if (pop) begin
      out_valid_d = 1'b1;
      led_d       = led_n;
      relay_d     = relay_n;
      if (q_op_i.reply) begin
        out_d.tx_valid     = 1'b1;
        out_d.tx_byte      = REPLY_ROM[0];
        out_d.last         = 1'b0;
        out_d.led_levels   = led_q;
        out_d.relay_level  = relay_q;
        out_d.beep_request = 1'b0;
        busy_d             = 1'b1;
        idx_d              = RIDX_W'(1);
      end else begin
        out_d.tx_valid     = 1'b0;
        out_d.tx_byte      = '0;
        out_d.last         = 1'b1;
        out_d.led_levels   = led_n;
        out_d.relay_level  = relay_n;
        out_d.beep_request = q_op_i.beep;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      led_q       <= 3'b111;
      relay_q     <= 1'b0;
      busy_q      <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      led_q       <= led_d;
      relay_q     <= relay_d;
      busy_q      <= busy_d;
      idx_q       <= idx_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> out_valid_q)
    else $error("reply in progress without a held output item");

  a_reply_no_beep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.tx_valid |-> !out_q.beep_request)
    else $error("reply byte flagged as beeper request");

  a_reply_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.tx_valid && out_q.last |-> !busy_q)
    else $error("reply sequencer still busy after final byte");

  a_led_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> $stable(led_q))
    else $error("led state changed during a reply");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/uart_command_frame_controller.sv
// an accepted item is stored in the op queue, its result in the output register
// throughput: one item per cycle unless the queue is full or the output stalls;
//   a status reply holds the output for 42 bytes; the two-entry op queue then
//   fills and stalls the input; temperature digits settle once a temperature
//   item has passed the queue, the back end and the converter pipeline
// reset: asynchronous active low; leds dark, relay off, frame count and
//   temperature characters zero; no clearing pass, ready right after reset
`default_nettype none

module uart_command_frame_controller import ucfc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic push, q_full, q_valid, pop;
  op_t  push_op, q_op;

  // frame assembly and classification
  ucfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  // decoupling queue
  ucfc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .op_o      (q_op)
  );

  // execution and reply output
  ucfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> dv/uart_command_frame_controller_test.sv
// self-checking testbench for the uart command frame controller
// depends on ucfc_pkg and the uart_command_frame_controller rtl only
`timescale 1ns / 1ps

module uart_command_frame_controller_test;
  import ucfc_pkg::*;

  // item kind and button index with no named code in the package
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0] BTN_NONE  = 2'd3;
  localparam int         N_ITEMS   = 170;
  localparam int         IDLE_PCT  = 24;

  // fixed start of every status reply, the link send command
  localparam logic [7:0] SEND_HEAD [17] = '{
    8'h41, 8'h54, 8'h2B, 8'h43, 8'h49, 8'h50, 8'h53, 8'h45, 8'h4E,
    8'h44, 8'h3D, 8'h30, 8'h2C, 8'h32, 8'h36, 8'h0D, 8'h0A
  };

  typedef struct {
    in_t data;
    bit  drain;
  } stim_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  uart_command_frame_controller uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  stim_t pending[$];
  out_t  results_due[$];
  int    in_acc_cnt   = 0;
  int    in_sent_cnt  = 0;
  int    results_seen = 0;
  int    errors       = 0;
  int    n_replies    = 0;
  int    n_beeps      = 0;
  int    n_stim       = 0;
  int    gen_fcount   = 0;
  bit    drain_next   = 1'b0;
  logic  calm;

  // shadow of the controller state
  logic [7:0] fb [FRAME_LEN];
  int         fcnt   = 0;
  logic [2:0] leds   = 3'b111;
  logic       relay  = 1'b0;
  logic [7:0] tchars [TEMP_CHARS];

  // no random idling on either side for a stretch of the run
  assign calm = (in_acc_cnt >= 40) && (in_acc_cnt < 90);

  initial begin
    foreach (fb[i]) fb[i] = 8'h00;
    foreach (tchars[i]) tchars[i] = 8'h00;
  end

  // raw reading to tenths of a degree, sign folded in as 0x8000 + magnitude
  function automatic logic [15:0] to_tenths(input logic [15:0] t);
    logic [15:0] mag;
    logic [15:0] prod;
    if (t == TEMP_ERR) return TEMP_ERR;
    if (t > TEMP_NEG) begin
      mag  = 16'(17'h10000 - 17'(t));
      prod = 16'(32'(mag) * 5);
      return 16'(32'(TEMP_NEG) + 32'(prod / 16'd8));
    end
    prod = 16'(32'(t) * 5);
    return prod / 16'd8;
  endfunction

  // 42-byte status reply: led states and stored temperature characters
  function automatic void queue_status_reply();
    logic [7:0] rb [REPLY_LEN];
    out_t       r;
    for (int n = 0; n < 17; n++) rb[n] = SEND_HEAD[n];
    rb[17] = CH_E;
    rb[18] = CH_S;
    rb[19] = CH_P;
    for (int i = 0; i < 3; i++) begin
      rb[20 + 5 * i] = CH_L;
      rb[21 + 5 * i] = CH_E;
      rb[22 + 5 * i] = CH_D;
      rb[23 + 5 * i] = 8'(CH_ONE + i);
      rb[24 + 5 * i] = leds[i] ? CH_G : CH_K;
    end
    for (int i = 0; i < TEMP_CHARS; i++) rb[35 + i] = tchars[i];
    rb[39] = CH_P;
    rb[40] = CH_S;
    rb[41] = CH_E;
    for (int k = 0; k < REPLY_LEN; k++) begin
      r = '{tx_valid: 1'b1, tx_byte: rb[k], last: (k == REPLY_LEN - 1),
            led_levels: leds, relay_level: relay, beep_request: 1'b0};
      results_due.push_back(r);
    end
    n_replies++;
  endfunction

  // state update for one accepted item and the results it causes
  function automatic void run_controller_item(input in_t it);
    logic       beep;
    logic [15:0] v;
    logic [2:0] m;
    bit         on;
    bit         off;
    out_t       r;
    beep = 1'b0;
    case (it.func)
      FUNC_RX: begin
        if (fcnt >= FRAME_LEN) fcnt = 0;
        fb[fcnt] = it.rx_byte;
        if (fb[0] == CH_E) fcnt++;
        else fcnt = 0;
        if (fcnt >= FRAME_LEN) begin
          fcnt = 0;
          if (fb[0] == CH_E && fb[1] == CH_S && fb[2] == CH_P) begin
            on  = (fb[3] == CH_K);
            off = (fb[3] == CH_G);
            if (fb[4] == CH_L && fb[5] == CH_E && fb[6] == CH_D &&
                fb[7] >= CH_ONE && fb[7] <= CH_THREE) begin
              m = 3'(1 << (fb[7] - CH_ONE));
              if (on) leds = leds & ~m;
              if (off) leds = leds | m;
            end
            if (fb[4] == CH_J && fb[5] == CH_D && fb[6] == CH_Q && fb[7] == CH_ONE) begin
              if (on) relay = 1'b1;
              if (off) relay = 1'b0;
            end
            if (fb[3] == CH_F && fb[4] == CH_M && fb[5] == CH_Q &&
                fb[6] == CH_C && fb[7] == CH_S) begin
              beep = 1'b1;
              n_beeps++;
            end
            if (fb[3] == CH_C && fb[4] == CH_X && fb[5] == CH_S && fb[6] == CH_J) begin
              queue_status_reply();
              return;
            end
          end
        end
      end
      FUNC_TEMP: begin
        v = to_tenths(it.temp_raw);
        tchars[0] = 8'(CH_ZERO + (int'(v) % 1000) / 100);
        tchars[1] = 8'(CH_ZERO + (int'(v) % 100) / 10);
        tchars[2] = CH_DOT;
        tchars[3] = 8'(CH_ZERO + int'(v) % 10);
      end
      FUNC_BUTTON: begin
        if (it.button_index != BTN_NONE) leds = leds ^ 3'(1 << it.button_index);
      end
      default: ;
    endcase
    r = '{tx_valid: 1'b0, tx_byte: 8'h00, last: 1'b1,
          led_levels: leds, relay_level: relay, beep_request: beep};
    results_due.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("mismatch on result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (results_due.size() == 0) begin
      report_mismatch("result with nothing expected, tx_byte", got.tx_byte, 0);
      return;
    end
    want = results_due.pop_front();
    if (got.tx_valid !== want.tx_valid) report_mismatch("tx_valid", got.tx_valid, want.tx_valid);
    if (got.tx_byte !== want.tx_byte) report_mismatch("tx_byte", got.tx_byte, want.tx_byte);
    if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    if (got.led_levels !== want.led_levels)
      report_mismatch("led_levels", got.led_levels, want.led_levels);
    if (got.relay_level !== want.relay_level)
      report_mismatch("relay_level", got.relay_level, want.relay_level);
    if (got.beep_request !== want.beep_request)
      report_mismatch("beep_request", got.beep_request, want.beep_request);
  endtask

  // monitor: input items into the shadow state, result items against it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        run_controller_item(in_data_i);
        in_acc_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        results_seen++;
      end
    end
  end

  // driver: present pending items and stall the result side at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!in_valid_i || in_acc_cnt == in_sent_cnt) begin
        if (pending.size() == 0 || (!calm && $urandom_range(0, 99) < IDLE_PCT) ||
            (pending[0].drain && results_due.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          in_data_i  <= pending[0].data;
          in_valid_i <= 1'b1;
          void'(pending.pop_front());
          in_sent_cnt++;
        end
      end
    end
  end

  // queue one item; the caller supplies every field, also the unused ones
  task automatic push_item(input logic [1:0] f, input logic [7:0] b,
                           input logic [15:0] t, input logic [1:0] bi);
    stim_t s;
    s.data.func         = f;
    s.data.rx_byte      = b;
    s.data.temp_raw     = t;
    s.data.button_index = bi;
    s.drain             = drain_next;
    drain_next          = 1'b0;
    pending.push_back(s);
    n_stim++;
    if (f == FUNC_RX) begin
      if (gen_fcount == 0) gen_fcount = (b == CH_E) ? 1 : 0;
      else gen_fcount++;
      if (gen_fcount >= FRAME_LEN) gen_fcount = 0;
    end
  endtask

  task automatic push_rx(input logic [7:0] b);
    push_item(FUNC_RX, b, 16'($urandom), 2'($urandom));
  endtask

  // finish any partial frame first so the new frame starts at position zero
  task automatic push_frame(input logic [7:0] fr [FRAME_LEN]);
    while (gen_fcount != 0) push_rx(8'($urandom));
    for (int i = 0; i < FRAME_LEN; i++) push_rx(fr[i]);
  endtask

  task automatic push_random_frame();
    logic [7:0] fr [FRAME_LEN];
    int         kind;
    foreach (fr[i]) fr[i] = 8'($urandom);
    fr[0] = CH_E;
    fr[1] = CH_S;
    fr[2] = CH_P;
    kind = $urandom_range(0, 8);
    // led and relay commands mostly well formed, sometimes a bad selector or number
    if (kind <= 2 || kind == 3 || kind == 4) begin
      case ($urandom_range(0, 5))
        0: fr[3] = 8'($urandom);
        1, 2: fr[3] = CH_G;
        default: fr[3] = CH_K;
      endcase
    end
    case (kind)
      0, 1, 2: begin
        fr[4] = CH_L;
        fr[5] = CH_E;
        fr[6] = CH_D;
        fr[7] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(8'h2F, 8'h34))
                                            : 8'($urandom_range(CH_ONE, CH_THREE));
      end
      3, 4: begin
        fr[4] = CH_J;
        fr[5] = CH_D;
        fr[6] = CH_Q;
        fr[7] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : CH_ONE;
      end
      5: begin
        fr[3] = CH_F;
        fr[4] = CH_M;
        fr[5] = CH_Q;
        fr[6] = CH_C;
        fr[7] = CH_S;
      end
      6: begin
        fr[3] = CH_C;
        fr[4] = CH_X;
        fr[5] = CH_S;
        fr[6] = CH_J;
      end
      7: ;  // unknown command after the prefix
      default: begin
        // anchored frame without the full prefix
        fr[$urandom_range(1, 2)] = 8'($urandom);
      end
    endcase
    push_frame(fr);
  endtask

  function automatic logic [15:0] pick_reading();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return TEMP_ERR;
      2: return TEMP_NEG;
      3: return 16'h8001;
      4: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus, reset, end of run
  initial begin
    logic [7:0] fr [FRAME_LEN];
    int         pick;

    // directed: reading extremes, every item kind, both button ends, a status reply
    push_item(FUNC_TEMP, 8'hFF, 16'h0000, 2'd3);
    push_item(FUNC_TEMP, 8'h00, TEMP_ERR, 2'd0);
    push_item(FUNC_TEMP, 8'hFF, TEMP_NEG, 2'd3);
    push_item(FUNC_TEMP, 8'h00, 16'h8001, 2'd0);
    push_item(FUNC_TEMP, 8'hFF, 16'h7FFF, 2'd3);
    push_item(FUNC_BUTTON, 8'h00, 16'hFFFF, 2'd0);
    push_item(FUNC_BUTTON, 8'hFF, 16'h0000, 2'd1);
    push_item(FUNC_BUTTON, 8'h00, 16'hFFFF, 2'd2);
    push_item(FUNC_BUTTON, 8'hFF, 16'h0000, BTN_NONE);
    push_item(FUNC_NONE, 8'hFF, 16'hFFFF, 2'd3);
    push_rx(8'h00);
    push_rx(8'hFF);
    fr = '{CH_E, CH_S, CH_P, CH_C, CH_X, CH_S, CH_J, 8'h00, 8'hFF, 8'h00};
    push_frame(fr);

    // random: mostly command frames, plus noise, readings and buttons
    drain_next = 1'b1;
    while (n_stim < N_ITEMS) begin
      if (n_stim >= 110 && n_stim < 120) drain_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) push_random_frame();
      else if (pick < 60) push_rx(($urandom_range(0, 3) == 0) ? CH_E : 8'($urandom));
      else if (pick < 78) push_item(FUNC_TEMP, 8'($urandom), pick_reading(), 2'($urandom));
      else if (pick < 93)
        push_item(FUNC_BUTTON, 8'($urandom), 16'($urandom), 2'($urandom_range(0, 3)));
      else push_item(FUNC_NONE, 8'($urandom), 16'($urandom), 2'($urandom));
    end
    // one last reply so the final led and temperature state is read back
    fr = '{CH_E, CH_S, CH_P, CH_C, CH_X, CH_S, CH_J, 8'h5A, 8'hA5, 8'h3C};
    push_frame(fr);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_acc_cnt != in_sent_cnt) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (results_due.size() != 0)
      report_mismatch("results never delivered, count", results_due.size(), 0);

    $display("covered %0d items incl. %0d status replies and %0d beeper commands",
             in_acc_cnt, n_replies, n_beeps);
    $display("checked %0d result items, %0d mismatches", results_seen, errors);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
